// ----- rtl/oldest_first_issue_scheduler_macros.svh -----
// Assertion macros for the issue scheduler.
`ifndef OLDEST_FIRST_ISSUE_SCHEDULER_MACROS_SVH
`define OLDEST_FIRST_ISSUE_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define OFIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ofis assertion failed");
`define OFIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ofis assertion failed");
`else
`define OFIS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OFIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ofis_pkg.sv -----
// ----------------------------------------------------------------------------
// ofis_pkg
// Types and codes shared by the issue scheduler modules.
// ----------------------------------------------------------------------------
package ofis_pkg;

  localparam int unsigned IDX_W = 7;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEALLOC   = 3'd1;
  localparam logic [2:0] OP_PICK      = 3'd2;
  localparam logic [2:0] OP_RELEASE   = 3'd3;
  localparam logic [2:0] OP_SET_READY = 3'd4;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic [7:0] SLOT_FREE = 8'hFF;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ISSUE
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_SHIFT
  } state_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [IDX_W-1:0] idx;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0] rob_id;
    logic [2:0] port;
    logic [4:0] latency;
    logic       src1_valid;
    logic [6:0] src1_reg;
    logic       src2_valid;
    logic [6:0] src2_reg;
    logic       issued;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  rob_id;
    logic [2:0]  port;
    logic [31:0] cycle;
    logic [4:0]  latency;
    logic        src1_valid;
    logic [6:0]  src1_reg;
    logic        src2_valid;
    logic [6:0]  src2_reg;
    logic        tracker_select;
    logic [31:0] ready_cycle;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       issued_valid;
    logic [7:0] issued_rob_id;
    logic [5:0] free_entries;
  } out_word_t;

endpackage

// ----- rtl/oldest_first_issue_scheduler.sv -----
// ----------------------------------------------------------------------------
// oldest_first_issue_scheduler
// Age-ordered reservation station with oldest-first pick and slot rings.
// ----------------------------------------------------------------------------
// One word in, one word out. Insert, release, set-ready and unused opcodes
// finish in the accept cycle. Deallocate walks the entry chain one cell a
// cycle from the oldest; on a match S_SHIFT removes that entry, and without
// one the result is given at the last entry. Pick also walks from the
// oldest; an entry on another port or already issued is skipped in S_FETCH,
// and a candidate also passes S_EVAL, as the ready-cycle and slot RAMs have
// a registered read. A new word is taken only when no result waits at the
// output, or in the cycle that result is taken. Slot and ready tables use
// valid bits; there is no clearing pass after reset.
module oldest_first_issue_scheduler
  import ofis_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 32,
  parameter int unsigned PORT_COUNT  = 8,
  parameter int unsigned WINDOW_LOG2 = 5,
  parameter int unsigned PHYS_REGS   = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

`include "oldest_first_issue_scheduler_macros.svh"

  localparam int unsigned IW    = $clog2(ENTRY_COUNT);
  localparam int unsigned OW    = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned SLOTS = PORT_COUNT << WINDOW_LOG2;
  localparam int unsigned SA_W  = $clog2(SLOTS);
  localparam int unsigned RA_W  = $clog2(PHYS_REGS);

  state_e             state_q, state_d;
  logic [IW-1:0]      si_q, si_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [5:0]         active_q;
  logic [2:0]         op_q, op_d;
  logic [7:0]         rob_q, rob_d;
  logic [2:0]         port_q, port_d;
  logic [31:0]        cyc_q, cyc_d;
  entry_t             ent_q, ent_d;
  logic [SA_W-1:0]    xa_q, xa_d, wa_q, wa_d;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_set;

  cell_ctl_t          ctl;
  entry_t             new_ent, cur;
  entry_t             cells [ENTRY_COUNT];

  logic               slot_we_x, slot_we_w, rr_we;
  logic [SA_W-1:0]    slot_wa_x, slot_wa_w;
  logic [7:0]         slot_wd;
  logic [7:0]         ex_rd, wb_rd;
  logic [31:0]        rr1_rd, rr2_rd;
  logic               acc, last, full, ok;
  logic [31:0]        wb_sum;

  function automatic logic [5:0] free_of(input logic [OW-1:0] occ, input logic [5:0] act);
    logic [31:0] c;
    c = (32'(act) > ENTRY_COUNT) ? ENTRY_COUNT : 32'(act);
    return (32'(occ) >= c) ? 6'd0 : 6'(c - 32'(occ));
  endfunction

  function automatic logic [SA_W-1:0] slot_addr(input logic [2:0] p, input logic [31:0] c);
    return SA_W'((32'(p) << WINDOW_LOG2) | (c & ((32'd1 << WINDOW_LOG2) - 32'd1)));
  endfunction

  function automatic logic src_ok(input logic v, input logic [6:0] r, input logic [31:0] rd,
                                  input logic [31:0] c);
    return !v || (32'(r) >= PHYS_REGS) || (rd <= c);
  endfunction

  // ---- entry chain ----
  assign new_ent = '{rob_id: in_word_i.rob_id, port: in_word_i.port,
                     latency: in_word_i.latency, src1_valid: in_word_i.src1_valid,
                     src1_reg: in_word_i.src1_reg, src2_valid: in_word_i.src2_valid,
                     src2_reg: in_word_i.src2_reg, issued: 1'b0};

  for (genvar j = 0; j < ENTRY_COUNT; j++) begin : g_cell
    ofis_cell #(.IDX(j)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .load_i (new_ent),
      .next_i ((j == ENTRY_COUNT - 1) ? cells[j] : cells[(j + 1) % ENTRY_COUNT]),
      .entry_o(cells[j])
    );
  end

  assign cur = cells[si_q];

  // ---- tables ----
  assign wb_sum = cyc_q + 32'(cur.latency);

  ofis_vram #(.DEPTH(SLOTS), .WIDTH(8), .RST_VAL(SLOT_FREE)) u_ex (
    .clk_i, .rst_ni, .we_i(slot_we_x), .waddr_i(slot_wa_x), .wdata_i(slot_wd),
    .raddr_i(slot_addr(port_q, cyc_q)), .rdata_o(ex_rd)
  );

  ofis_vram #(.DEPTH(SLOTS), .WIDTH(8), .RST_VAL(SLOT_FREE)) u_wb (
    .clk_i, .rst_ni, .we_i(slot_we_w), .waddr_i(slot_wa_w), .wdata_i(slot_wd),
    .raddr_i(slot_addr(port_q, wb_sum)), .rdata_o(wb_rd)
  );

  ofis_vram #(.DEPTH(PHYS_REGS), .WIDTH(32), .RST_VAL(32'd0)) u_rr1 (
    .clk_i, .rst_ni, .we_i(rr_we), .waddr_i(RA_W'(in_word_i.src1_reg)),
    .wdata_i(in_word_i.ready_cycle), .raddr_i(RA_W'(cur.src1_reg)), .rdata_o(rr1_rd)
  );

  ofis_vram #(.DEPTH(PHYS_REGS), .WIDTH(32), .RST_VAL(32'd0)) u_rr2 (
    .clk_i, .rst_ni, .we_i(rr_we), .waddr_i(RA_W'(in_word_i.src1_reg)),
    .wdata_i(in_word_i.ready_cycle), .raddr_i(RA_W'(cur.src2_reg)), .rdata_o(rr2_rd)
  );

  // ---- control ----
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign last       = (32'(si_q) + 32'd1) >= 32'(occ_q);
  assign full       = (free_of(occ_q, active_q) == 6'd0) || (32'(occ_q) >= ENTRY_COUNT);
  assign ok         = src_ok(ent_q.src1_valid, ent_q.src1_reg, rr1_rd, cyc_q)
                   && src_ok(ent_q.src2_valid, ent_q.src2_reg, rr2_rd, cyc_q)
                   && (ex_rd == SLOT_FREE) && (wb_rd == SLOT_FREE);

  always_comb begin
    state_d   = state_q;
    si_d      = si_q;
    occ_d     = occ_q;
    op_d      = op_q;
    rob_d     = rob_q;
    port_d    = port_q;
    cyc_d     = cyc_q;
    ent_d     = ent_q;
    xa_d      = xa_q;
    wa_d      = wa_q;
    ctl       = '{cmd: CELL_HOLD, idx: IDX_W'(si_q)};
    out_set   = 1'b0;
    out_d     = '{status: STATUS_DONE, issued_valid: 1'b0, issued_rob_id: 8'd0,
                  free_entries: 6'd0};
    slot_we_x = 1'b0;
    slot_we_w = 1'b0;
    slot_wa_x = slot_addr(in_word_i.port, in_word_i.cycle);
    slot_wa_w = slot_addr(in_word_i.port, in_word_i.cycle);
    slot_wd   = SLOT_FREE;
    rr_we     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          op_d   = in_word_i.opcode;
          rob_d  = in_word_i.rob_id;
          port_d = in_word_i.port;
          cyc_d  = in_word_i.cycle;
          si_d   = '0;
          case (in_word_i.opcode)
            OP_INSERT: begin
              out_set = 1'b1;
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                ctl   = '{cmd: CELL_LOAD, idx: IDX_W'(occ_q)};
                occ_d = occ_q + OW'(1);
              end
            end
            OP_DEALLOC: begin
              if (occ_q == '0) out_set = 1'b1;
              else state_d = S_FETCH;
            end
            OP_PICK: begin
              if (occ_q == '0 || 32'(in_word_i.port) >= PORT_COUNT) begin
                out_set      = 1'b1;
                out_d.status = STATUS_NONE;
              end else begin
                state_d = S_FETCH;
              end
            end
            OP_RELEASE: begin
              out_set = 1'b1;
              if (32'(in_word_i.port) < PORT_COUNT) begin
                slot_we_w = in_word_i.tracker_select;
                slot_we_x = !in_word_i.tracker_select;
              end
            end
            OP_SET_READY: begin
              out_set = 1'b1;
              rr_we   = 32'(in_word_i.src1_reg) < PHYS_REGS;
            end
            default: out_set = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        if (op_q == OP_DEALLOC) begin
          if (cur.rob_id == rob_q) begin
            state_d = S_SHIFT;
          end else if (last) begin
            out_set = 1'b1;
            state_d = S_IDLE;
          end else begin
            si_d = si_q + IW'(1);
          end
        end else if (cur.port != port_q || cur.issued) begin
          if (last) begin
            out_set      = 1'b1;
            out_d.status = STATUS_NONE;
            state_d      = S_IDLE;
          end else begin
            si_d = si_q + IW'(1);
          end
        end else begin
          ent_d   = cur;
          xa_d    = slot_addr(port_q, cyc_q);
          wa_d    = slot_addr(port_q, wb_sum);
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (ok) begin
          slot_we_x           = 1'b1;
          slot_we_w           = 1'b1;
          slot_wa_x           = xa_q;
          slot_wa_w           = wa_q;
          slot_wd             = ent_q.rob_id;
          ctl                 = '{cmd: CELL_ISSUE, idx: IDX_W'(si_q)};
          out_set             = 1'b1;
          out_d.issued_valid  = 1'b1;
          out_d.issued_rob_id = ent_q.rob_id;
          state_d             = S_IDLE;
        end else if (last) begin
          out_set      = 1'b1;
          out_d.status = STATUS_NONE;
          state_d      = S_IDLE;
        end else begin
          si_d    = si_q + IW'(1);
          state_d = S_FETCH;
        end
      end
      S_SHIFT: begin
        ctl     = '{cmd: CELL_SHIFT, idx: IDX_W'(si_q)};
        occ_d   = occ_q - OW'(1);
        out_set = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_d.free_entries = free_of(occ_d, active_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      si_q        <= '0;
      occ_q       <= '0;
      active_q    <= 6'd32;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      si_q    <= si_d;
      occ_q   <= occ_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (out_set) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rob_q  <= rob_d;
    port_q <= port_d;
    cyc_q  <= cyc_d;
    ent_q  <= ent_d;
    xa_q   <= xa_d;
    wa_q   <= wa_d;
    if (out_set) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `OFIS_ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `OFIS_ASSERT_IMPL(a_occ_bound, clk_i, rst_ni, 1'b1, 32'(occ_q) <= ENTRY_COUNT)
  `OFIS_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, acc && in_word_i.opcode == OP_INSERT && !full, occ_q == $past(occ_q) + OW'(1))
  `OFIS_ASSERT_NEXT(a_shift_result, clk_i, rst_ni, state_q == S_SHIFT, out_valid_o && occ_q == $past(occ_q) - OW'(1))

endmodule

// ----- rtl/ofis_cell.sv -----
// ----------------------------------------------------------------------------
// ofis_cell
// One station entry; loads, takes its younger neighbor on a shift, marks issue.
// ----------------------------------------------------------------------------
module ofis_cell
  import ofis_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    load_i,
  input  entry_t    next_i,
  output entry_t    entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CELL_LOAD: begin
        if (ctl_i.idx == IDX_W'(IDX)) entry_q <= load_i;
      end
      CELL_SHIFT: begin
        // entries from the removed one upward move down one place
        if (IDX_W'(IDX) >= ctl_i.idx) entry_q <= next_i;
      end
      CELL_ISSUE: begin
        if (ctl_i.idx == IDX_W'(IDX)) entry_q.issued <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/ofis_vram.sv -----
// ----------------------------------------------------------------------------
// ofis_vram
// Single-port-write, registered-read RAM; unwritten entries read as RST_VAL.
// ----------------------------------------------------------------------------
module ofis_vram #(
  parameter int unsigned DEPTH   = 256,
  parameter int unsigned WIDTH   = 8,
  parameter logic [WIDTH-1:0] RST_VAL = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic             rvld_q;
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) valid_q[waddr_i] <= 1'b1;
      rvld_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rvld_q ? rdata_q : RST_VAL;

endmodule
